// ===== rtl/core/rppf_pkg.sv =====
// ----------------------------------------------------------------------------
// rppf_pkg
// Shared types and constants of the RGB pixel point filter: filter mode
// codes, register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package rppf_pkg;

   localparam int CHAN_W        = 8;   // one input channel sample
   localparam int NOISE_W       = 7;   // signed noise offset
   localparam int OUT_W         = 9;   // one filtered channel
   localparam int MODE_W        = 3;
   localparam int WIDTH_REG_W   = 13;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 13;
   localparam int NUM_CHAN      = 3;

   localparam int SEGMENT_LENGTH_DEF = 5;
   localparam int MAX_WIDTH_DEF      = 4096;

   localparam logic [WIDTH_REG_W-1:0] IMAGE_WIDTH_RESET = WIDTH_REG_W'(640);

   typedef enum logic [MODE_W-1:0] {
      MODE_NEGATIVE     = 3'd0,
      MODE_CONTRAST     = 3'd1,
      MODE_REMOVE_RED   = 3'd2,
      MODE_REMOVE_GREEN = 3'd3,
      MODE_REMOVE_BLUE  = 3'd4,
      MODE_GRAY         = 3'd5,
      MODE_NOISE        = 3'd6,
      MODE_SEGMENT      = 3'd7
   } filter_mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FILTER_MODE = 2'd0,
      CSR_IMAGE_WIDTH = 2'd1
   } csr_index_type;

   typedef struct packed {
      filter_mode_type             filter_mode;
      logic [WIDTH_REG_W-1:0]      image_width;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/core/rppf_csr.sv =====
// ----------------------------------------------------------------------------
// rppf_csr
// Configuration registers: filter mode and image width.
// ----------------------------------------------------------------------------
`default_nettype none

module rppf_csr
   import rppf_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output      cfg_type                cfg
);

   filter_mode_type          mode_ff;
   logic [WIDTH_REG_W-1:0]   width_ff;

   assign csr_ready = 1'b1;

   // drop writes to unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NEGATIVE;
         width_ff <= IMAGE_WIDTH_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FILTER_MODE: begin
               mode_ff <= filter_mode_type'(csr_data[MODE_W-1:0]);
            end
            CSR_IMAGE_WIDTH: begin
               width_ff <= csr_data[WIDTH_REG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg.filter_mode = mode_ff;
   assign cfg.image_width = width_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rppf_seg.sv =====
// ----------------------------------------------------------------------------
// rppf_seg
// Segment accumulator: column and segment counters, running channel sums
// and their averages over the segment length.
// ----------------------------------------------------------------------------
`default_nettype none

module rppf_seg
   import rppf_pkg::*;
#(
   parameter int SEGMENT_LENGTH = SEGMENT_LENGTH_DEF,
   parameter int MAX_WIDTH      = MAX_WIDTH_DEF
)
(
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              advance,
   input  wire logic [WIDTH_REG_W-1:0]            image_width,
   input  wire logic [NUM_CHAN-1:0][CHAN_W-1:0]   chan,
   output      logic [NUM_CHAN-1:0][CHAN_W-1:0]   average
);

   localparam int SEG_W   = (SEGMENT_LENGTH > 2) ? $clog2(SEGMENT_LENGTH) : 1;
   localparam int SUM_W   = $clog2(SEGMENT_LENGTH * 255 + 1);
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int RECIP_K = SUM_W + SEG_W + 1;
   localparam int RECIP   = ((2 ** RECIP_K) + SEGMENT_LENGTH - 1) / SEGMENT_LENGTH;
   localparam int PROD_W  = SUM_W + RECIP_K;

   localparam logic [RECIP_K-1:0] RECIP_V  = RECIP_K'(RECIP);
   localparam logic [SEG_W:0]     SEG_LEN  = (SEG_W + 1)'(SEGMENT_LENGTH);
   localparam logic [COL_W:0]     MAX_W_V  = (COL_W + 1)'(MAX_WIDTH);

   logic [COL_W-1:0]                  col_ff;
   logic [COL_W-1:0]                  col_in;
   logic [SEG_W-1:0]                  pos_ff;
   logic [SEG_W-1:0]                  pos_in;
   logic [NUM_CHAN-1:0][SUM_W-1:0]    sums_ff;
   logic [NUM_CHAN-1:0][SUM_W-1:0]    sums_in;

   logic [SEG_W-1:0]                  pos_cur;
   logic [SEG_W:0]                    pos_inc;
   logic [COL_W:0]                    col_inc;
   logic [COL_W:0]                    width_eff;
   logic [PROD_W-1:0]                 prod [NUM_CHAN];

   // clamp width: zero acts as one, anything above the maximum as the maximum
   always_comb begin
      if (image_width == '0) begin
         width_eff = (COL_W + 1)'(1);
      end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
         width_eff = MAX_W_V;
      end else begin
         width_eff = (COL_W + 1)'(image_width);
      end
   end

   always_comb begin
      // a new row restarts the segment
      pos_cur = (col_ff == '0) ? '0 : pos_ff;
      for (int c = 0; c < NUM_CHAN; c++) begin
         sums_in[c] = ((pos_cur == '0) ? '0 : sums_ff[c]) + SUM_W'(chan[c]);
         prod[c]    = PROD_W'(sums_in[c]) * PROD_W'(RECIP_V);
         average[c] = prod[c][RECIP_K +: CHAN_W];
      end
      pos_inc = (SEG_W + 1)'(pos_cur) + (SEG_W + 1)'(1);
      pos_in  = (pos_inc >= SEG_LEN) ? '0 : pos_inc[SEG_W-1:0];
      col_inc = (COL_W + 1)'(col_ff) + (COL_W + 1)'(1);
      col_in  = (col_inc >= width_eff) ? '0 : col_inc[COL_W-1:0];
   end

   // advance on every pixel whatever the mode
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         pos_ff  <= '0;
         sums_ff <= '0;
      end else if (advance) begin
         col_ff  <= col_in;
         pos_ff  <= pos_in;
         sums_ff <= sums_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/rppf_filter.sv =====
// ----------------------------------------------------------------------------
// rppf_filter
// Per-pixel filter datapath: selects the filtered channels by mode.
// ----------------------------------------------------------------------------
`default_nettype none

module rppf_filter
   import rppf_pkg::*;
(
   input  wire filter_mode_type                   filter_mode,
   input  wire logic [NUM_CHAN-1:0][CHAN_W-1:0]   chan,
   input  wire logic [NUM_CHAN-1:0][NOISE_W-1:0]  noise,
   input  wire logic [NUM_CHAN-1:0][CHAN_W-1:0]   average,
   output      logic [NUM_CHAN-1:0][OUT_W-1:0]    result
);

   // divide by three: multiply by ceil(2^16 / 3), exact for sums below 1024
   localparam int GRAY_SHIFT = 16;
   localparam int GRAY_SUM_W = 10;
   localparam int GRAY_PROD_W = GRAY_SUM_W + GRAY_SHIFT;
   localparam logic [GRAY_SHIFT-1:0] GRAY_RECIP = GRAY_SHIFT'(21846);
   localparam int NSUM_W = CHAN_W + 2;

   logic [GRAY_SUM_W-1:0]           gray_sum;
   logic [GRAY_PROD_W-1:0]          gray_prod;
   logic [CHAN_W-1:0]               gray;
   logic signed [NSUM_W-1:0]        nsum [NUM_CHAN];
   logic [NSUM_W-1:0]               nabs [NUM_CHAN];

   always_comb begin
      gray_sum  = GRAY_SUM_W'(chan[0]) + GRAY_SUM_W'(chan[1]) + GRAY_SUM_W'(chan[2]);
      gray_prod = GRAY_PROD_W'(gray_sum) * GRAY_PROD_W'(GRAY_RECIP);
      gray      = gray_prod[GRAY_SHIFT +: CHAN_W];
      for (int c = 0; c < NUM_CHAN; c++) begin
         nsum[c] = signed'({2'b00, chan[c]}) +
                   signed'({{(NSUM_W - NOISE_W){noise[c][NOISE_W-1]}}, noise[c]});
         nabs[c] = nsum[c][NSUM_W-1] ? NSUM_W'(-nsum[c]) : NSUM_W'(nsum[c]);
      end
   end

   always_comb begin
      result = '0;
      case (filter_mode)
         MODE_NEGATIVE: begin
            for (int c = 0; c < NUM_CHAN; c++) begin
               result[c] = OUT_W'({1'b0, ~chan[c]});
            end
         end
         MODE_CONTRAST: begin
            for (int c = 0; c < NUM_CHAN; c++) begin
               result[c] = chan[c][CHAN_W-1] ? OUT_W'(8'hFF) : '0;
            end
         end
         MODE_REMOVE_RED: begin
            result[1] = OUT_W'(chan[1]);
            result[2] = OUT_W'(chan[2]);
         end
         MODE_REMOVE_GREEN: begin
            result[0] = OUT_W'(chan[0]);
            result[2] = OUT_W'(chan[2]);
         end
         MODE_REMOVE_BLUE: begin
            result[0] = OUT_W'(chan[0]);
            result[1] = OUT_W'(chan[1]);
         end
         MODE_GRAY: begin
            for (int c = 0; c < NUM_CHAN; c++) begin
               result[c] = OUT_W'(gray);
            end
         end
         MODE_NOISE: begin
            for (int c = 0; c < NUM_CHAN; c++) begin
               result[c] = nabs[c][OUT_W-1:0];
            end
         end
         MODE_SEGMENT: begin
            for (int c = 0; c < NUM_CHAN; c++) begin
               result[c] = OUT_W'(average[c]);
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/rgb_pixel_point_filter.sv =====
// ----------------------------------------------------------------------------
// rgb_pixel_point_filter
// Point filter over an RGB pixel stream with a segment-average mode.
// ----------------------------------------------------------------------------
// One pixel word in, one filtered pixel word out, in raster order. The block
// has two register stages: an input register that captures the accepted
// word and a result register that holds the filtered word until the sink
// takes it. All filtering sits between them, so a word is taken every
// clock while the sink keeps up, and each accepted word moves from the
// input register into the result register when that one is free or
// is being drained.
// req_ready stays high while the result register is empty or being drained
// in the same cycle. filter_mode (register 0) picks the filter: negative,
// high contrast, remove red, green or blue, gray (truncated channel mean),
// noise (absolute value of channel plus the signed offset fields, up to
// 318), and segment average (running channel sums divided by
// SEGMENT_LENGTH, restarting every SEGMENT_LENGTH pixels and at each row
// start). image_width (register 1) sets the row length; zero acts as one
// and values above MAX_WIDTH as MAX_WIDTH. The column and segment counters
// advance on every pixel in every mode, so a switch into segment mode stays
// aligned. Write the registers only while no word is in flight; writes to
// unknown indexes are dropped. The configuration port never stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_pixel_point_filter
   import rppf_pkg::*;
#(
   parameter int SEGMENT_LENGTH = SEGMENT_LENGTH_DEF,
   parameter int MAX_WIDTH      = MAX_WIDTH_DEF
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,

   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire logic [CHAN_W-1:0]      req_red_in,
   input  wire logic [CHAN_W-1:0]      req_green_in,
   input  wire logic [CHAN_W-1:0]      req_blue_in,
   input  wire logic [NOISE_W-1:0]     req_red_noise,
   input  wire logic [NOISE_W-1:0]     req_green_noise,
   input  wire logic [NOISE_W-1:0]     req_blue_noise,

   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic [OUT_W-1:0]       rsp_red_out,
   output      logic [OUT_W-1:0]       rsp_green_out,
   output      logic [OUT_W-1:0]       rsp_blue_out
);

   cfg_type                              cfg;

   logic                                 in_valid_ff;
   logic [NUM_CHAN-1:0][CHAN_W-1:0]      chan_ff;
   logic [NUM_CHAN-1:0][NOISE_W-1:0]     noise_ff;
   logic                                 out_valid_ff;
   logic                                 out_valid_in;
   logic [NUM_CHAN-1:0][OUT_W-1:0]       result_ff;

   logic                                 advance;
   logic                                 req_take;
   logic [NUM_CHAN-1:0][CHAN_W-1:0]      average;
   logic [NUM_CHAN-1:0][OUT_W-1:0]       result;

   // move a word from the input register into the result register when
   // the result register is free or being taken this cycle
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   // hold the captured word until it advances
   always_ff @(posedge clock) begin
      if (req_take) begin
         chan_ff  <= {req_blue_in, req_green_in, req_red_in};
         noise_ff <= {req_blue_noise, req_green_noise, req_red_noise};
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   rppf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rppf_seg #(
      .SEGMENT_LENGTH (SEGMENT_LENGTH),
      .MAX_WIDTH      (MAX_WIDTH)
   ) u_seg (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .image_width (cfg.image_width),
      .chan        (chan_ff),
      .average     (average)
   );

   rppf_filter u_filter (
      .filter_mode (cfg.filter_mode),
      .chan        (chan_ff),
      .noise       (noise_ff),
      .average     (average),
      .result      (result)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_red_out   = result_ff[0];
   assign rsp_green_out = result_ff[1];
   assign rsp_blue_out  = result_ff[2];

endmodule

`default_nettype wire

// ===== dv/rgb_pixel_point_filter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_pixel_point_filter_checker
// Watches the register, pixel and result channels of the point filter. It
// keeps its own copy of the registers and of the row and segment counters,
// works out the filtered pixel for every accepted word, and compares each
// result word against the oldest outstanding one.
// ----------------------------------------------------------------------------

module rgb_pixel_point_filter_checker
   import rppf_pkg::*;
#(
   parameter int SEGMENT_LENGTH = SEGMENT_LENGTH_DEF,
   parameter int MAX_WIDTH      = MAX_WIDTH_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,

   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [CHAN_W-1:0]      req_red_in,
   input  logic [CHAN_W-1:0]      req_green_in,
   input  logic [CHAN_W-1:0]      req_blue_in,
   input  logic [NOISE_W-1:0]     req_red_noise,
   input  logic [NOISE_W-1:0]     req_green_noise,
   input  logic [NOISE_W-1:0]     req_blue_noise,

   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [OUT_W-1:0]       rsp_red_out,
   input  logic [OUT_W-1:0]       rsp_green_out,
   input  logic [OUT_W-1:0]       rsp_blue_out,

   output int                     pending_words,
   output int                     fail_count
);

   localparam int MISMATCH_REPORTS = 10;

   typedef struct packed {
      logic [OUT_W-1:0] red;
      logic [OUT_W-1:0] green;
      logic [OUT_W-1:0] blue;
   } filtered_pixel_type;

   filter_mode_type                mode_reg;
   logic [WIDTH_REG_W-1:0]         width_reg;
   logic [NUM_CHAN-1:0][10:0]      segment_sums;
   logic [2:0]                     segment_pos;
   logic [11:0]                    column;
   filtered_pixel_type             expected_pixels[$];
   int                             failures = 0;
   int                             words_checked = 0;

   // Filter one pixel and advance the row and segment counters.
   function automatic filtered_pixel_type filter_pixel(
      input logic [NUM_CHAN-1:0][CHAN_W-1:0]  chan,
      input logic [NUM_CHAN-1:0][NOISE_W-1:0] offset
   );
      int                            row_len;
      int                            level;
      logic [NUM_CHAN-1:0][OUT_W-1:0] value;
      row_len = (width_reg == 0) ? 1 : int'(width_reg);
      if (row_len > MAX_WIDTH) begin
         row_len = MAX_WIDTH;
      end
      if (column == 0) begin
         segment_pos = '0;
      end
      if (segment_pos == 0) begin
         segment_sums = '0;
      end
      for (int c = 0; c < NUM_CHAN; c++) begin
         segment_sums[c] = segment_sums[c] + chan[c];
      end
      case (mode_reg)
         MODE_NEGATIVE: begin
            for (int c = 0; c < NUM_CHAN; c++) value[c] = OUT_W'(255 - int'(chan[c]));
         end
         MODE_CONTRAST: begin
            for (int c = 0; c < NUM_CHAN; c++) value[c] = (chan[c] > 127) ? OUT_W'(255) : '0;
         end
         MODE_REMOVE_RED, MODE_REMOVE_GREEN, MODE_REMOVE_BLUE: begin
            for (int c = 0; c < NUM_CHAN; c++) value[c] = OUT_W'(chan[c]);
            value[int'(mode_reg) - int'(MODE_REMOVE_RED)] = '0;
         end
         MODE_GRAY: begin
            level = (int'(chan[0]) + int'(chan[1]) + int'(chan[2])) / 3;
            for (int c = 0; c < NUM_CHAN; c++) value[c] = OUT_W'(level);
         end
         MODE_NOISE: begin
            for (int c = 0; c < NUM_CHAN; c++) begin
               level = int'(chan[c]) + int'($signed(offset[c]));
               if (level < 0) begin
                  level = -level;
               end
               value[c] = OUT_W'(level);
            end
         end
         default: begin
            for (int c = 0; c < NUM_CHAN; c++) begin
               value[c] = OUT_W'(segment_sums[c] / SEGMENT_LENGTH);
            end
         end
      endcase
      segment_pos = (int'(segment_pos) + 1 >= SEGMENT_LENGTH) ? '0 : segment_pos + 1'b1;
      column      = (int'(column) + 1 >= row_len) ? '0 : column + 1'b1;
      return {value[0], value[1], value[2]};
   endfunction

   always @(posedge clock) begin
      filtered_pixel_type got;
      filtered_pixel_type want;
      filtered_pixel_type next_pixel;
      if (reset) begin
         mode_reg     = MODE_NEGATIVE;
         width_reg    = IMAGE_WIDTH_RESET;
         segment_sums = '0;
         segment_pos  = '0;
         column       = '0;
         expected_pixels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FILTER_MODE: mode_reg = filter_mode_type'(csr_data[MODE_W-1:0]);
               CSR_IMAGE_WIDTH: width_reg = csr_data[WIDTH_REG_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_red_out, rsp_green_out, rsp_blue_out};
            if (expected_pixels.size() == 0) begin
               if (failures < MISMATCH_REPORTS) begin
                  $display("word %0d: result %0d/%0d/%0d with no pixel outstanding",
                           words_checked, got.red, got.green, got.blue);
               end
               failures++;
            end else begin
               want = expected_pixels.pop_front();
               if (got.red != want.red || got.green != want.green || got.blue != want.blue) begin
                  if (failures < MISMATCH_REPORTS) begin
                     $display("word %0d: expected r/g/b %0d/%0d/%0d, got %0d/%0d/%0d",
                              words_checked, want.red, want.green, want.blue,
                              got.red, got.green, got.blue);
                  end
                  failures++;
               end
            end
            words_checked++;
         end
         if (req_valid && req_ready) begin
            next_pixel = filter_pixel(
               {req_blue_in, req_green_in, req_red_in},
               {req_blue_noise, req_green_noise, req_red_noise});
            expected_pixels.insert(expected_pixels.size(), next_pixel);
         end
      end
      pending_words <= expected_pixels.size();
      fail_count    <= failures;
   end

endmodule

// ===== dv/rgb_pixel_point_filter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_pixel_point_filter_test
// Stimulus and verdict for the RGB pixel point filter.
// ----------------------------------------------------------------------------
// Runs a short directed sweep through every filter mode with extreme channel
// and noise values, then a long series of random phases. Each phase sets the
// mode and, in most phases, the row width while the block is idle (zero, one, tiny, the row
// limit, above it, the register maximum, and widths lowered mid-row), then
// streams random pixel words with random gaps on both sides. One phase holds
// the result side off for a long stretch so the block backs up. A final
// short phase runs segment mode with the width register at its maximum.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------

module rgb_pixel_point_filter_test;
   import rppf_pkg::*;

   localparam int RANDOM_ITEMS   = 1850;
   localparam int LONG_ROW_ITEMS = 50;      // segment run at the clamped width
   localparam int HOLDOFF_CYCLES = 400;
   localparam int DRAIN_CYCLES   = 4;       // two register stages, plus margin
   localparam int QUIET_FIRST    = 1000;    // no idling on either side in here
   localparam int QUIET_LAST     = 2000;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int WIDTH_REG_MAX  = (1 << WIDTH_REG_W) - 1;

   // Indexes that decode to no register; writes there must be dropped.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 2'd3;

   typedef struct packed {
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
      logic [NOISE_W-1:0] red_noise;
      logic [NOISE_W-1:0] green_noise;
      logic [NOISE_W-1:0] blue_noise;
   } pixel_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [CHAN_W-1:0]      req_red_in = '0;
   logic [CHAN_W-1:0]      req_green_in = '0;
   logic [CHAN_W-1:0]      req_blue_in = '0;
   logic [NOISE_W-1:0]     req_red_noise = '0;
   logic [NOISE_W-1:0]     req_green_noise = '0;
   logic [NOISE_W-1:0]     req_blue_noise = '0;

   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [OUT_W-1:0]       rsp_red_out;
   logic [OUT_W-1:0]       rsp_green_out;
   logic [OUT_W-1:0]       rsp_blue_out;

   int                     pending_words;
   int                     fail_count;
   int                     cycle_count = 0;
   int                     holdoff_requests = 0;
   int                     holdoff_served = 0;
   int                     holdoff_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rgb_pixel_point_filter dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .req_red_noise   (req_red_noise),
      .req_green_noise (req_green_noise),
      .req_blue_noise  (req_blue_noise),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_red_out     (rsp_red_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_blue_out    (rsp_blue_out)
   );

   rgb_pixel_point_filter_checker pixel_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .req_red_noise   (req_red_noise),
      .req_green_noise (req_green_noise),
      .req_blue_noise  (req_blue_noise),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_red_out     (rsp_red_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_blue_out    (rsp_blue_out),
      .pending_words   (pending_words),
      .fail_count      (fail_count)
   );

   // Watchdog: a hung handshake or a lost result word ends up here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("rgb_pixel_point_filter test failed");
         $finish;
      end
   end

   // Idle about one cycle in ten, except inside the quiet window.
   function automatic bit roll_idle();
      return (cycle_count < QUIET_FIRST || cycle_count >= QUIET_LAST) &&
             ($urandom_range(99) < 10);
   endfunction

   // Result sink: random stalls, plus a long hold-off whenever the stimulus
   // asks for one, so the block fills and backs up its input.
   always @(posedge clock) begin
      if (holdoff_left != 0) begin
         rsp_ready    <= 1'b0;
         holdoff_left <= holdoff_left - 1;
      end else if (holdoff_served != holdoff_requests) begin
         rsp_ready      <= 1'b0;
         holdoff_served <= holdoff_served + 1;
         holdoff_left   <= HOLDOFF_CYCLES;
      end else begin
         rsp_ready <= !roll_idle();
      end
   end

   // Mostly uniform samples, with the contrast threshold and the rails mixed in.
   function automatic logic [CHAN_W-1:0] channel_sample();
      logic [CHAN_W-1:0] sample;
      sample = CHAN_W'($urandom_range(255));
      if ($urandom_range(3) == 0) begin
         case ($urandom_range(3))
            0: sample = 8'd0;
            1: sample = 8'd255;
            2: sample = 8'd127;
            default: sample = 8'd128;
         endcase
      end
      return sample;
   endfunction

   function automatic pixel_word_type random_pixel();
      pixel_word_type px;
      px.red         = channel_sample();
      px.green       = channel_sample();
      px.blue        = channel_sample();
      // Take the whole 7-bit offset range, not just the nominal one.
      px.red_noise   = NOISE_W'($urandom_range(127));
      px.green_noise = NOISE_W'($urandom_range(127));
      px.blue_noise  = NOISE_W'($urandom_range(127));
      return px;
   endfunction

   // Rails, threshold neighbours and the noise extremes (-64, 63, -50, 49, -1).
   function automatic pixel_word_type directed_pixel(input int k);
      case (k)
         0:       return {8'd0,   8'd255, 8'd127, 7'h40, 7'h3F, 7'h00};
         1:       return {8'd128, 8'd1,   8'd254, 7'h7F, 7'h4E, 7'h31};
         default: return {8'd255, 8'd255, 8'd255, 7'h3F, 7'h40, 7'h7F};
      endcase
   endfunction

   // Offer one pixel word and hold it until the block takes it. Valid is
   // left high so the next word can follow straight on.
   task automatic offer_pixel(input pixel_word_type px);
      while (roll_idle()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_red_in      <= px.red;
      req_green_in    <= px.green;
      req_blue_in     <= px.blue;
      req_red_noise   <= px.red_noise;
      req_green_noise <= px.green_noise;
      req_blue_noise  <= px.blue_noise;
      do @(posedge clock); while (!req_ready);
   endtask

   // One register write; valid stays up for a following write.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0]  data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_filter(input logic [CSR_DATA_W-1:0] mode_word, input int width,
                             input bit write_width, input bit poke_spare);
      csr_write(CSR_FILTER_MODE, mode_word);
      if (write_width) begin
         csr_write(CSR_IMAGE_WIDTH, CSR_DATA_W'(width));
      end
      if (poke_spare) begin
         csr_write($urandom_range(1) ? CSR_SPARE_HIGH : CSR_SPARE_LOW,
                   CSR_DATA_W'($urandom));
      end
      csr_valid <= 1'b0;
   endtask

   // Start with a clock edge: the checker's count is registered behind the handshake.
   task automatic wait_until_drained();
      do @(posedge clock); while (pending_words != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic stream_random(input int count);
      for (int i = 0; i < count; i++) begin
         offer_pixel(random_pixel());
      end
      req_valid <= 1'b0;
      wait_until_drained();
   endtask

   initial begin
      int                    phase;
      int                    sent;
      int                    count;
      int                    width;
      filter_mode_type       mode;
      logic [CSR_DATA_W-1:0] mode_word;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults first: negative filter, 640-pixel rows.
      offer_pixel(directed_pixel(2));
      req_valid <= 1'b0;
      wait_until_drained();

      // Directed sweep: every mode against the extreme words.
      for (int m = 0; m < 8; m++) begin
         set_filter(CSR_DATA_W'(filter_mode_type'(m)), 0, 1'b0, 1'b0);
         for (int k = 0; k < 3; k++) begin
            offer_pixel(directed_pixel(k));
         end
         req_valid <= 1'b0;
         wait_until_drained();
      end

      // Random phases: step through the widths of interest, modes in order
      // first and then at random, junk in the unused mode bits.
      phase = 0;
      sent  = 0;
      while (sent < RANDOM_ITEMS) begin
         if (phase < 8) begin
            mode = filter_mode_type'(phase);
         end else begin
            mode = filter_mode_type'($urandom_range(7));
         end
         case (phase % 12)
            0:  width = 1;
            1:  width = 0;
            2:  width = 2;
            3:  width = WIDTH_REG_MAX;
            4:  width = MAX_WIDTH_DEF;
            5:  width = $urandom_range(3, 12);
            6:  width = 640;
            7:  width = 3;                     // lowered below the column
            8:  width = $urandom_range(0, WIDTH_REG_MAX);
            9:  width = SEGMENT_LENGTH_DEF;
            10: width = MAX_WIDTH_DEF + 1;
            default: width = $urandom_range(13, 40);
         endcase
         mode_word = CSR_DATA_W'($urandom);
         mode_word[MODE_W-1:0] = mode;
         if (phase == 3) begin
            holdoff_requests <= holdoff_requests + 1;
         end
         set_filter(mode_word, width, phase % 7 != 6, phase % 4 == 3);
         count = $urandom_range(20, 80);
         stream_random(count);
         sent  += count;
         phase += 1;
      end

      // Segment mode with the width register at its maximum, clamped in the block.
      set_filter(CSR_DATA_W'(MODE_SEGMENT), WIDTH_REG_MAX, 1'b1, 1'b0);
      stream_random(LONG_ROW_ITEMS);

      if (fail_count == 0) begin
         $display("rgb_pixel_point_filter test passed");
      end else begin
         $display("rgb_pixel_point_filter test failed");
      end
      $finish;
   end

endmodule

// ===== rgb_pixel_point_filter.f =====
rtl/core/rppf_pkg.sv
rtl/core/rppf_csr.sv
rtl/core/rppf_seg.sv
rtl/core/rppf_filter.sv
rtl/core/rgb_pixel_point_filter.sv
dv/rgb_pixel_point_filter_checker.sv
dv/rgb_pixel_point_filter_test.sv
